FILE: rtl/mpdsf_pkg.sv
// Package for the MIPS delay-slot filler: opcode codes, queue sizing and the
// instruction decode functions. No dependencies.
`default_nettype none

package mpdsf_pkg;

    localparam int unsigned WORD_W = 32;

    // Output queue: one accepted item can release up to three result items.
    localparam int unsigned MAX_OUT = 3;
    localparam int unsigned QDEPTH  = 6;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SC_TOP  = 6'h2E;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [4:0] REG_RA     = 5'd31;

    typedef struct packed {
        logic       valid;
        logic [4:0] num;
    } dest_t;

    function automatic logic [5:0] f_op(input logic [WORD_W-1:0] w);
        return w[31:26];
    endfunction

    function automatic logic is_jump(input logic [WORD_W-1:0] w);
        logic [5:0] op;
        op = w[31:26];
        if (op == OP_SPECIAL) begin
            return (w[5:0] == FN_JR) || (w[5:0] == FN_JALR);
        end
        return (op >= OP_REGIMM) && (op <= OP_BGTZ);
    endfunction

    function automatic logic is_store(input logic [5:0] op);
        return (op >= OP_SB) && (op <= OP_SC_TOP);
    endfunction

    // Destination register of a word; valid is low when nothing is written.
    function automatic dest_t dest_reg(input logic [WORD_W-1:0] w);
        dest_t      d;
        logic [5:0] op;
        op      = w[31:26];
        d.valid = 1'b1;
        d.num   = w[20:16];
        if (w == '0) begin
            d.valid = 1'b0;
        end else if (op == OP_SPECIAL) begin
            if (w[5:0] == FN_JR) begin
                d.valid = 1'b0;
            end else if (w[5:0] == FN_JALR) begin
                d.num = REG_RA;
            end else begin
                d.num = w[15:11];
            end
        end else if (op == OP_JAL) begin
            d.num = REG_RA;
        end else if (op == OP_REGIMM || op == OP_J ||
                     (op >= OP_BEQ && op <= OP_BGTZ) || is_store(op)) begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    // True when word w reads register r. Register zero never counts.
    function automatic logic reads_reg(input logic [WORD_W-1:0] w, input logic [4:0] r);
        logic [5:0] op;
        logic       rs_hit;
        logic       rt_hit;
        logic       rd_hit;
        op     = w[31:26];
        rs_hit = (w[25:21] == r);
        rt_hit = (w[20:16] == r);
        rd_hit = (w[15:11] == r);
        if (r == 5'd0) begin
            return 1'b0;
        end
        if (op == OP_SPECIAL) begin
            if (w[5:0] == FN_JR) begin
                return rs_hit;
            end
            if (w[5:0] == FN_JALR) begin
                return rs_hit || rd_hit;
            end
            return rs_hit || rt_hit;
        end
        if (op == OP_REGIMM) begin
            return rs_hit;
        end
        if (op == OP_J || op == OP_JAL || op == OP_LUI) begin
            return 1'b0;
        end
        if ((op >= OP_BEQ && op <= OP_BGTZ) || is_store(op)) begin
            return rs_hit || rt_hit;
        end
        return rs_hit;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mips_peephole_delay_slot_filler_top.sv
// Top level of the MIPS peephole rewriter with branch delay-slot filling.
// Depends on mpdsf_pkg for decode functions and queue sizing.
`default_nettype none

// The block rewrites a stream of 32-bit MIPS instruction words, grouped into
// blocks by s_tlast, and returns exactly as many words per block, in order,
// with m_tlast on the final one. A LUI that repeats the previous word's LUI
// target and immediate becomes a NOP. When a branch (J, JAL, JR, JALR or
// opcodes 1 to 7) is followed by a NOP, the non-branch, non-NOP word before
// the branch moves into the delay slot and its own place becomes a NOP,
// unless the branch reads that word's destination register or the word
// itself sits in a delay slot. Up to two words are held back inside the block
// until they can no longer change; they leave as soon as that is known and
// all of them leave on the word that carries s_tlast, so output lags input by
// up to two items. An input item is decoded in the cycle it is accepted and
// its results land in a six-entry output queue, so a new item is taken every
// cycle while the queue holds three items or fewer; the queue gives one item
// per cycle on the output side while m_tready is high, which sets the rate at
// one item per cycle. s_tready does not depend on m_tready in the same cycle.
module mips_peephole_delay_slot_filler_top
    import mpdsf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [WORD_W-1:0] s_tdata,   // [31:0] in_word
    input  wire logic              s_tlast,   // in_last
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [WORD_W-1:0]      m_tdata,   // [31:0] out_word
    output logic                   m_tlast    // out_last
);

    // Window state: the previous word after the LUI rewrite, and the two held
    // words. held_cnt_reg counts held words (0..2).
    logic [WORD_W-1:0] lui_prev_reg;
    logic [WORD_W-1:0] older_reg;
    logic [WORD_W-1:0] middle_reg;
    logic [1:0]        held_cnt_reg;
    logic              older_after_br_reg;

    logic [WORD_W-1:0] lui_prev_next;
    logic [WORD_W-1:0] older_next;
    logic [WORD_W-1:0] middle_next;
    logic [1:0]        held_cnt_next;
    logic              older_after_br_next;

    // Output queue: entry 0 is the head shown on the m_ side.
    logic [WORD_W-1:0] q_word_reg [QDEPTH];
    logic              q_last_reg [QDEPTH];
    logic [QCNT_W-1:0] q_cnt_reg;
    logic [WORD_W-1:0] q_word_next [QDEPTH];
    logic              q_last_next [QDEPTH];
    logic [QCNT_W-1:0] q_cnt_next;

    logic              accept;
    logic              pop;
    logic [WORD_W-1:0] w;
    logic              moved;
    dest_t             older_dest;

    // Result items released by the current input item, in order.
    logic [WORD_W-1:0] res_word [MAX_OUT];
    logic              res_last [MAX_OUT];
    logic [1:0]        res_n;

    logic [QCNT_W-1:0] cnt_mid;
    logic [QCNT_W:0]   offset;

    assign s_tready = (q_cnt_reg <= QCNT_W'(QDEPTH - MAX_OUT));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (q_cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = q_word_reg[0];
    assign m_tlast  = q_last_reg[0];

    always_comb begin
        // Pass 1: a repeated LUI collapses to NOP.
        w = s_tdata;
        if (f_op(s_tdata) == OP_LUI && f_op(lui_prev_reg) == OP_LUI &&
            s_tdata[20:16] == lui_prev_reg[20:16] &&
            s_tdata[15:0] == lui_prev_reg[15:0]) begin
            w = '0;
        end

        // Pass 2: fill the delay slot of the held branch with the older word.
        older_dest = dest_reg(older_reg);
        moved = (held_cnt_reg == 2'd2) && is_jump(middle_reg) && (w == '0) &&
                !older_after_br_reg && (older_reg != '0) && !is_jump(older_reg) &&
                (!older_dest.valid || !reads_reg(middle_reg, older_dest.num));

        lui_prev_next       = w;
        older_next          = older_reg;
        middle_next         = middle_reg;
        held_cnt_next       = held_cnt_reg;
        older_after_br_next = older_after_br_reg;
        res_n               = 2'd0;
        for (int k = 0; k < MAX_OUT; k++) begin
            res_word[k] = '0;
            res_last[k] = 1'b0;
        end

        if (held_cnt_reg == 2'd2) begin
            if (moved) begin
                res_word[0]         = '0;
                res_word[1]         = middle_reg;
                res_word[2]         = older_reg;
                res_last[2]         = s_tlast;
                res_n               = 2'd3;
                held_cnt_next       = 2'd0;
                older_after_br_next = 1'b0;
            end else begin
                res_word[0]         = older_reg;
                res_n               = 2'd1;
                older_after_br_next = is_jump(older_reg);
                older_next          = middle_reg;
                middle_next         = w;
                if (s_tlast) begin
                    res_word[1] = middle_reg;
                    res_word[2] = w;
                    res_last[2] = 1'b1;
                    res_n       = 2'd3;
                end
            end
        end else if (held_cnt_reg == 2'd1) begin
            middle_next   = w;
            held_cnt_next = 2'd2;
            if (s_tlast) begin
                res_word[0] = older_reg;
                res_word[1] = w;
                res_last[1] = 1'b1;
                res_n       = 2'd2;
            end
        end else begin
            older_next          = w;
            older_after_br_next = 1'b0;
            held_cnt_next       = 2'd1;
            if (s_tlast) begin
                res_word[0] = w;
                res_last[0] = 1'b1;
                res_n       = 2'd1;
            end
        end

        // The end of a block flushes the window and the LUI history.
        if (s_tlast) begin
            held_cnt_next       = 2'd0;
            older_after_br_next = 1'b0;
            lui_prev_next       = '0;
            older_next          = '0;
            middle_next         = '0;
        end
    end

    // Queue update: shift out the head, then append the new results.
    always_comb begin
        cnt_mid = q_cnt_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                q_word_next[i] = q_word_reg[i + 1];
                q_last_next[i] = q_last_reg[i + 1];
            end else begin
                q_word_next[i] = q_word_reg[i];
                q_last_next[i] = q_last_reg[i];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            offset = (QCNT_W + 1)'(i) - {1'b0, cnt_mid};
            if (accept && !offset[QCNT_W] && offset < (QCNT_W + 1)'(res_n)) begin
                q_word_next[i] = res_word[offset[1:0]];
                q_last_next[i] = res_last[offset[1:0]];
            end
        end
        q_cnt_next = cnt_mid + (accept ? QCNT_W'(res_n) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lui_prev_reg       <= '0;
            older_reg          <= '0;
            middle_reg         <= '0;
            held_cnt_reg       <= 2'd0;
            older_after_br_reg <= 1'b0;
            q_cnt_reg          <= '0;
        end else begin
            if (accept) begin
                lui_prev_reg       <= lui_prev_next;
                older_reg          <= older_next;
                middle_reg         <= middle_next;
                held_cnt_reg       <= held_cnt_next;
                older_after_br_reg <= older_after_br_next;
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_word_reg[i] <= q_word_next[i];
            q_last_reg[i] <= q_last_next[i];
        end
    end

endmodule

`default_nettype wire

FILE: test/mpdsf_stream_checker.sv
// Checker for the MIPS delay-slot filler: watches both stream channels, predicts
// the rewritten words and compares them item by item. Depends on mpdsf_pkg.
module mpdsf_stream_checker
    import mpdsf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [WORD_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [WORD_W-1:0] m_tdata,
    input  wire logic              m_tlast,
    output int                     error_count,
    output int                     expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    // Marks a word that writes no register.
    localparam logic [5:0] NO_DEST = 6'd32;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              eob;
    } out_item_t;

    out_item_t rewritten_q[$];

    logic [WORD_W-1:0] prev_lui;
    logic [WORD_W-1:0] older;
    logic [WORD_W-1:0] middle;
    logic [1:0]        held;
    logic              older_in_slot;

    function automatic logic jump_op(input logic [WORD_W-1:0] w);
        if (w[31:26] == OP_SPECIAL) begin
            return (w[5:0] == FN_JR) || (w[5:0] == FN_JALR);
        end
        return (w[31:26] >= OP_REGIMM) && (w[31:26] <= OP_BGTZ);
    endfunction

    function automatic logic [5:0] writes_to(input logic [WORD_W-1:0] w);
        logic [5:0] op;
        op = w[31:26];
        if (w == '0) begin
            return NO_DEST;
        end
        if (op == OP_SPECIAL) begin
            if (w[5:0] == FN_JR) begin
                return NO_DEST;
            end
            if (w[5:0] == FN_JALR) begin
                return {1'b0, REG_RA};
            end
            return {1'b0, w[15:11]};
        end
        if (op == OP_JAL) begin
            return {1'b0, REG_RA};
        end
        if (op == OP_REGIMM || op == OP_J || (op >= OP_BEQ && op <= OP_BGTZ) ||
            (op >= OP_SB && op <= OP_SC_TOP)) begin
            return NO_DEST;
        end
        return {1'b0, w[20:16]};
    endfunction

    function automatic logic reads_from(input logic [WORD_W-1:0] w, input logic [4:0] r);
        logic [5:0] op;
        logic       rs_hit;
        logic       rt_hit;
        logic       rd_hit;
        op     = w[31:26];
        rs_hit = (w[25:21] == r);
        rt_hit = (w[20:16] == r);
        rd_hit = (w[15:11] == r);
        if (r == 5'd0) begin
            return 1'b0;
        end
        if (op == OP_SPECIAL) begin
            if (w[5:0] == FN_JR) begin
                return rs_hit;
            end
            if (w[5:0] == FN_JALR) begin
                return rs_hit || rd_hit;
            end
            return rs_hit || rt_hit;
        end
        if (op == OP_REGIMM) begin
            return rs_hit;
        end
        if (op == OP_J || op == OP_JAL || op == OP_LUI) begin
            return 1'b0;
        end
        if ((op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_SB && op <= OP_SC_TOP)) begin
            return rs_hit || rt_hit;
        end
        return rs_hit;
    endfunction

    // Applies one accepted word to the window and queues the words it releases.
    task automatic rewrite_word(input logic [WORD_W-1:0] w_in, input logic eob_in);
        logic [WORD_W-1:0] w;
        logic [5:0]        dest;
        logic              moved;
        int                released;
        out_item_t         tail_item;
        w        = w_in;
        moved    = 1'b0;
        released = 0;
        if (w[31:26] == OP_LUI && prev_lui[31:26] == OP_LUI &&
            w[20:16] == prev_lui[20:16] && w[15:0] == prev_lui[15:0]) begin
            w = '0;
        end
        prev_lui = w;

        if (held == 2'd2) begin
            if (jump_op(middle) && w == '0 && !older_in_slot && older != '0 &&
                !jump_op(older)) begin
                dest = writes_to(older);
                moved = (dest == NO_DEST) || !reads_from(middle, dest[4:0]);
            end
            if (moved) begin
                rewritten_q.push_back('{word: '0, eob: 1'b0});
                rewritten_q.push_back('{word: middle, eob: 1'b0});
                rewritten_q.push_back('{word: older, eob: 1'b0});
                released      = 3;
                held          = 2'd0;
                older_in_slot = 1'b0;
            end else begin
                rewritten_q.push_back('{word: older, eob: 1'b0});
                released      = 1;
                older_in_slot = jump_op(older);
                older         = middle;
                middle        = w;
            end
        end else if (held == 2'd1) begin
            middle = w;
            held   = 2'd2;
        end else begin
            older         = w;
            older_in_slot = 1'b0;
            held          = 2'd1;
        end

        if (eob_in) begin
            if (held >= 2'd1) begin
                rewritten_q.push_back('{word: older, eob: 1'b0});
                released++;
            end
            if (held == 2'd2) begin
                rewritten_q.push_back('{word: middle, eob: 1'b0});
                released++;
            end
            if (released > 0) begin
                tail_item     = rewritten_q.pop_back();
                tail_item.eob = 1'b1;
                rewritten_q.push_back(tail_item);
            end
            held          = 2'd0;
            older_in_slot = 1'b0;
            prev_lui      = '0;
            older         = '0;
            middle        = '0;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            prev_lui      = '0;
            older         = '0;
            middle        = '0;
            held          = 2'd0;
            older_in_slot = 1'b0;
            rewritten_q.delete();
        end else begin
            // Input first, so an item leaving at the same edge still finds its
            // prediction if the block were ever to pass one straight through.
            if (s_tvalid && s_tready) begin
                rewrite_word(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (rewritten_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual word %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_tdata !== want.word) begin
                        error_count++;
                        $display("%0t: word mismatch, expected %h, actual %h",
                                 $time, want.word, m_tdata);
                    end
                    if (m_tlast !== want.eob) begin
                        error_count++;
                        $display("%0t: last flag mismatch on word %h, expected %b, actual %b",
                                 $time, want.word, want.eob, m_tlast);
                    end
                end
            end
        end
        expected_left = rewritten_q.size();
    end

endmodule

FILE: test/mips_peephole_delay_slot_filler_top_tb.sv
// Testbench top for the MIPS delay-slot filler: clock, reset, directed and
// random instruction blocks, random back-pressure and the verdict.
// Depends on mpdsf_pkg, the block itself and mpdsf_stream_checker.
module mips_peephole_delay_slot_filler_top_tb;
    import mpdsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes and function codes used only to build stimulus words.
    localparam logic [5:0] OP_ORI  = 6'h0D;
    localparam logic [5:0] OP_LW   = 6'h23;
    localparam logic [5:0] OP_SW   = 6'h2B;
    localparam logic [5:0] FN_ADDU = 6'h21;

    // The block never lets many cycles pass without moving an item unless one
    // side stalls, and the random stalls are far shorter, so this is ample.
    localparam int STALL_LIMIT = 2000;
    // Words are held at most two deep, so a short drain after the last
    // expected item catches anything extra the block might still emit.
    localparam int DRAIN_CYCLES = 20;
    // Input items to send in total, directed ones included.
    localparam int ITEM_TARGET = 160;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata  = '0;   // [31:0] in_word
    logic              s_tlast  = 1'b0; // in_last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;         // [31:0] out_word
    logic              m_tlast;         // out_last

    int   error_count;
    int   expected_left;
    int   items_sent  = 0;
    int   ready_hold  = 0;
    int   quiet_cycles = 0;
    // When set, neither side idles, so the block runs at full rate.
    logic no_idle = 1'b0;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    mips_peephole_delay_slot_filler_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mpdsf_stream_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .expected_left (expected_left)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 2);
        end
        if (r < 97) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 30);
    endfunction

    function automatic logic [WORD_W-1:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                                input logic [4:0] rd, input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [WORD_W-1:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                                input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Registers are drawn mostly from a handful of low numbers so that the
    // branch often reads the register the word before it writes, and $0 shows
    // up often enough to exercise the rule that writes to $0 may always move.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 8) begin
            return 5'($urandom_range(0, 3));
        end
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [WORD_W-1:0] jump_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 5))
            0: begin
                w = {OP_J, 26'($urandom())};
            end
            1: begin
                w = {OP_JAL, 26'($urandom())};
            end
            2: begin
                w = enc_r(pick_reg(), 5'd0, 5'd0, FN_JR);
            end
            3: begin
                w = enc_r(pick_reg(), 5'd0, ($urandom_range(0, 1) != 0) ? REG_RA : pick_reg(),
                          FN_JALR);
            end
            4: begin
                w = enc_i(OP_REGIMM, pick_reg(), 5'($urandom()), 16'($urandom()));
            end
            default: begin
                w = enc_i(6'($urandom_range(OP_BEQ, OP_BGTZ)), pick_reg(), pick_reg(),
                          16'($urandom()));
            end
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] nonjump_word();
        logic [5:0]        fn;
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 3))
            0: begin
                fn = 6'($urandom());
                if (fn == FN_JR || fn == FN_JALR) begin
                    fn = FN_ADDU;
                end
                w = enc_r(pick_reg(), pick_reg(), pick_reg(), fn);
            end
            1: begin
                w = enc_i(6'($urandom_range(OP_ORI - 5, 63)), pick_reg(), pick_reg(),
                          16'($urandom()));
            end
            2: begin
                w = enc_i(6'($urandom_range(OP_SB, OP_SC_TOP)), pick_reg(), pick_reg(),
                          16'($urandom()));
            end
            default: begin
                w = enc_i(OP_LW, pick_reg(), pick_reg(), 16'($urandom()));
            end
        endcase
        return w;
    endfunction

    // LUI with a target and immediate from a small set, so repeats are common;
    // rs is random because the repeat rule must ignore it.
    function automatic logic [WORD_W-1:0] lui_word();
        logic [15:0] imm;
        case ($urandom_range(0, 3))
            0: imm = 16'h0000;
            1: imm = 16'hFFFF;
            2: imm = 16'h1234;
            default: imm = 16'($urandom());
        endcase
        return enc_i(OP_LUI, 5'($urandom()), 5'($urandom_range(0, 2)), imm);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return jump_word();
        end
        if (r < 40) begin
            return '0;
        end
        if (r < 52) begin
            return lui_word();
        end
        if (r < 90) begin
            return nonjump_word();
        end
        return $urandom();
    endfunction

    // Offers one item and returns at the edge where it is taken. s_tvalid is
    // assigned at most once per edge, so back-to-back items keep it high.
    task automatic send_item(input logic [WORD_W-1:0] w, input logic eob);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // A random block. Most blocks are built from the shapes that reach the
    // delay-slot rewrite (a plain word, a branch, a NOP) and repeated LUIs,
    // mixed with loose words; one block in eight is pure noise.
    task automatic send_random_block();
        logic [WORD_W-1:0] words[$];
        logic [WORD_W-1:0] lui_w;
        logic              noise;
        int                len;
        int                r;
        noise = ($urandom_range(0, 7) == 0);
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        while (words.size() < len) begin
            r = $urandom_range(0, 9);
            if (noise) begin
                words.push_back($urandom());
            end else if (r < 4) begin
                words.push_back(($urandom_range(0, 5) == 0) ? jump_word() : nonjump_word());
                words.push_back(jump_word());
                words.push_back('0);
            end else if (r < 5) begin
                lui_w = lui_word();
                words.push_back(lui_w);
                words.push_back(lui_w);
            end else begin
                words.push_back(rand_word());
            end
        end
        no_idle <= ($urandom_range(0, 4) == 0);
        foreach (words[k]) begin
            send_item(words[k], k == words.size() - 1);
        end
    endtask

    // Result side: m_tready holds each random level for a random number of
    // cycles, which gives both single-cycle stalls and long ones.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= no_idle || ($urandom_range(0, 3) != 0);
            ready_hold <= no_idle ? 8 : idle_len();
        end
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A lone LUI: a one-word block only gets the LUI rewrite.
        send_item(enc_i(OP_LUI, 5'd0, 5'd1, 16'h1234), 1'b1);
        // Two LUIs with the same target and immediate in a short block; the second turns into a NOP.
        send_item(enc_i(OP_LUI, 5'd3, 5'd2, 16'hFFFF), 1'b0);
        send_item(enc_i(OP_LUI, 5'd7, 5'd2, 16'hFFFF), 1'b1);
        // ADDU, BEQ, NOP: the ADDU moves into the delay slot; an all-ones word
        // closes the block.
        send_item(enc_r(5'd1, 5'd2, 5'd3, FN_ADDU), 1'b0);
        send_item(enc_i(OP_BEQ, 5'd4, 5'd5, 16'h0010), 1'b0);
        send_item('0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        // The branch reads the register the ADDU writes, so nothing moves.
        send_item(enc_r(5'd1, 5'd2, 5'd4, FN_ADDU), 1'b0);
        send_item(enc_i(OP_BEQ, 5'd4, 5'd5, 16'hFFF0), 1'b0);
        send_item('0, 1'b1);
        // A word writing $0 may always move, here in front of a JR.
        send_item(enc_i(OP_ORI, 5'd1, 5'd0, 16'h00FF), 1'b0);
        send_item(enc_r(5'd7, 5'd0, 5'd0, FN_JR), 1'b0);
        send_item('0, 1'b1);
        // The ADDU sits in the delay slot of the J and must stay put, even
        // though a JAL and a NOP follow it.
        send_item({OP_J, 26'h3FF_FFFF}, 1'b0);
        send_item(enc_r(5'd1, 5'd2, 5'd6, FN_ADDU), 1'b0);
        send_item({OP_JAL, 26'h000_0000}, 1'b0);
        send_item('0, 1'b1);
        // Two moves in a row: a store before a REGIMM branch, then an ADDU
        // before a JALR. The word after the first move starts a fresh window.
        send_item(enc_i(OP_SW, 5'd3, 5'd2, 16'h0004), 1'b0);
        send_item(enc_i(OP_REGIMM, 5'd1, 5'd0, 16'h0008), 1'b0);
        send_item('0, 1'b0);
        send_item(enc_r(5'd1, 5'd2, 5'd8, FN_ADDU), 1'b0);
        send_item(enc_r(5'd9, 5'd0, REG_RA, FN_JALR), 1'b0);
        send_item('0, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            send_random_block();
        end
        s_tvalid <= 1'b0;

        // Let the checker take in the last item, then wait for every
        // predicted word to come out and give the block a short drain.
        @(posedge aclk);
        wait (expected_left == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
